// ===== design/stb_pkg.sv =====
// stb_pkg: types and constants shared by the timer bank and its shared adder
// no dependencies
package stb_pkg;

    localparam int TICK_W = 32;
    localparam int CH_W   = 3;
    localparam int OP_W   = 2;

    // operation codes of an input item
    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2
    } op_t;

    // result status codes
    typedef enum logic {
        ST_OK      = 1'b0,
        ST_BAD_ARG = 1'b1
    } status_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_INC,
        S_CMP,
        S_REARM,
        S_EMIT
    } state_t;

endpackage

// ===== design/software_timer_bank.sv =====
// software_timer_bank: bank of one-shot / periodic timer channels on a 32-bit tick
// depends on stb_pkg and stb_alu
//
// usage:
//   input channel (in_valid / in_stall) takes one item: op, channel, period,
//   repeat_req. op tick advances the counter and scans the channels; start arms
//   a channel at now + period; stop disarms it. in_stall is high while an item
//   is being worked on.
//   output channel (out_valid / out_stall) gives one result per firing channel
//   in index order, or one empty result; last marks the final result of an item.
//   start, stop and unused op codes give exactly one result.
// steps:
//   a tick goes through accept, increment, a compare step per channel, a rearm
//   step per firing periodic channel and an emit step per result. a start goes
//   through accept, start and emit; a stop or rejected start through accept and
//   emit. the start, increment, compare and rearm steps use the single shared adder.
// reset clears the tick counter and disarms all channels. a stalled result is
//   held in the output register; the block takes the next item meanwhile and
//   waits with its own result until the register frees up.
module software_timer_bank
    import stb_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OP_W-1:0]     op,
    input  logic [CH_W-1:0]     channel,
    input  logic [TICK_W-1:0]   period,
    input  logic                repeat_req,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                fired,
    output logic [CH_W-1:0]     fired_channel,
    output logic                status,
    output logic [TICK_W-1:0]   now,
    output logic                last
);

    // only channels reachable by a 3-bit index can ever be armed
    localparam int SLOTS = (CHANNELS < (1 << CH_W)) ? CHANNELS : (1 << CH_W);
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    state_t              state_reg, state_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [SLOTS-1:0]    mask_reg, mask_next;
    logic [SLOTS-1:0]    armed_reg, armed_next;
    logic [SLOTS-1:0]    periodic_reg, periodic_next;
    logic [IDX_W-1:0]    ch_reg, ch_next;
    logic [TICK_W-1:0]   per_reg, per_next;
    logic                rep_reg, rep_next;
    logic                status_reg, status_next;

    logic [TICK_W-1:0]   due_mem [SLOTS];
    logic [TICK_W-1:0]   period_mem [SLOTS];
    logic                due_we;
    logic [IDX_W-1:0]    due_widx;
    logic                period_we;

    logic                out_valid_reg, out_valid_next;
    logic                fired_reg, fired_next;
    logic [CH_W-1:0]     fired_ch_reg, fired_ch_next;
    logic                out_status_reg, out_status_next;
    logic [TICK_W-1:0]   now_reg, now_next;
    logic                last_reg, last_next;

    alu_op_t             alu_op;
    logic [TICK_W-1:0]   alu_b;
    logic [TICK_W-1:0]   alu_sum;

    logic                out_free;
    logic                ch_ok;
    logic [IDX_W-1:0]    low_idx;
    logic [SLOTS-1:0]    low_bit;
    logic                scan_end;

    stb_alu u_alu (
        .alu_op (alu_op),
        .a      (tick_reg),
        .b      (alu_b),
        .sum    (alu_sum)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign ch_ok    = (7'(channel) < 7'(CHANNELS));
    assign scan_end = (idx_reg == IDX_W'(SLOTS - 1));

    // lowest pending firing
    always_comb
    begin
        low_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                low_idx = IDX_W'(i);
            end
        end
        low_bit = mask_reg & (~mask_reg + SLOTS'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tick_reg      <= '0;
            armed_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            armed_reg     <= armed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        mask_reg       <= mask_next;
        periodic_reg   <= periodic_next;
        ch_reg         <= ch_next;
        per_reg        <= per_next;
        rep_reg        <= rep_next;
        status_reg     <= status_next;
        fired_reg      <= fired_next;
        fired_ch_reg   <= fired_ch_next;
        out_status_reg <= out_status_next;
        now_reg        <= now_next;
        last_reg       <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (due_we)
        begin
            due_mem[due_widx] <= alu_sum;
        end
        if (period_we)
        begin
            period_mem[ch_reg] <= per_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        tick_next       = tick_reg;
        idx_next        = idx_reg;
        mask_next       = mask_reg;
        armed_next      = armed_reg;
        periodic_next   = periodic_reg;
        ch_next         = ch_reg;
        per_next        = per_reg;
        rep_next        = rep_reg;
        status_next     = status_reg;
        due_we          = 1'b0;
        due_widx        = idx_reg;
        period_we       = 1'b0;
        alu_op          = ALU_ADD;
        alu_b           = per_reg;
        in_stall        = 1'b1;

        out_valid_next  = out_valid_reg && out_stall;
        fired_next      = fired_reg;
        fired_ch_next   = fired_ch_reg;
        out_status_next = out_status_reg;
        now_next        = now_reg;
        last_next       = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ch_next     = IDX_W'(channel);
                    per_next    = period;
                    rep_next    = repeat_req;
                    mask_next   = '0;
                    idx_next    = '0;
                    status_next = ST_OK;
                    state_next  = S_EMIT;
                    case (op)
                        OP_TICK:
                        begin
                            state_next = S_INC;
                        end
                        OP_START:
                        begin
                            if (!ch_ok || period == '0)
                            begin
                                status_next = ST_BAD_ARG;
                            end
                            else
                            begin
                                state_next = S_START;
                            end
                        end
                        OP_STOP:
                        begin
                            if (!ch_ok)
                            begin
                                status_next = ST_BAD_ARG;
                            end
                            else
                            begin
                                armed_next[IDX_W'(channel)] = 1'b0;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_START:
            begin
                alu_op                = ALU_ADD;
                alu_b                 = per_reg;
                due_we                = 1'b1;
                due_widx              = ch_reg;
                period_we             = 1'b1;
                periodic_next[ch_reg] = rep_reg;
                armed_next[ch_reg]    = 1'b1;
                state_next            = S_EMIT;
            end

            S_INC:
            begin
                alu_op     = ALU_ADD;
                alu_b      = TICK_W'(1);
                tick_next  = alu_sum;
                state_next = S_CMP;
            end

            S_CMP:
            begin
                // wrap-safe due test: sign of now - due
                alu_op = ALU_SUB;
                alu_b  = due_mem[idx_reg];
                if (armed_reg[idx_reg] && !alu_sum[TICK_W-1])
                begin
                    mask_next[idx_reg] = 1'b1;
                    if (periodic_reg[idx_reg])
                    begin
                        state_next = S_REARM;
                    end
                    else
                    begin
                        armed_next[idx_reg] = 1'b0;
                    end
                end
                if (state_next == S_CMP)
                begin
                    if (scan_end)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end

            S_REARM:
            begin
                alu_op = ALU_ADD;
                alu_b  = period_mem[idx_reg];
                due_we = 1'b1;
                if (scan_end)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_CMP;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    now_next        = tick_reg;
                    if (mask_reg == '0)
                    begin
                        fired_next    = 1'b0;
                        fired_ch_next = '0;
                        last_next     = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        fired_next    = 1'b1;
                        fired_ch_next = CH_W'(low_idx);
                        mask_next     = mask_reg & ~low_bit;
                        last_next     = ((mask_reg & ~low_bit) == '0);
                        if ((mask_reg & ~low_bit) == '0)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign fired         = fired_reg;
    assign fired_channel = fired_ch_reg;
    assign status        = out_status_reg;
    assign now           = now_reg;
    assign last          = last_reg;

    // the counter moves only in the increment step
    a_tick_only_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_INC) |=> (tick_reg == $past(tick_reg)))
        else $error("tick counter changed outside increment step");

    // a scan always starts at channel zero
    a_scan_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INC) |=> (state_reg == S_CMP && idx_reg == '0))
        else $error("scan did not start at channel zero");

    // loading the final result of an item returns the sequencer to idle
    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free && last_next) |=> (state_reg == S_IDLE))
        else $error("sequencer kept busy after final result");

endmodule

// ===== design/stb_alu.sv =====
// stb_alu: the one 32-bit adder/subtractor shared by the start, increment, compare and rearm steps
// depends on stb_pkg
module stb_alu
    import stb_pkg::*;
(
    input  alu_op_t             alu_op,
    input  logic [TICK_W-1:0]   a,
    input  logic [TICK_W-1:0]   b,
    output logic [TICK_W-1:0]   sum
);

    logic [TICK_W-1:0] b_eff;

    always_comb
    begin
        case (alu_op)
            ALU_SUB: b_eff = ~b;
            default: b_eff = b;
        endcase
    end

    // subtract is a + ~b + 1
    assign sum = a + b_eff + TICK_W'(alu_op == ALU_SUB);

endmodule

// ===== tb/sv/tb_software_timer_bank.sv =====
// tb_software_timer_bank: self-checking bench for the timer channel bank
// depends on stb_pkg and the software_timer_bank rtl; holds a shadow copy of the
// channel state that predicts every firing and checks each result in order
module tb_software_timer_bank;
    import stb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS    = 8;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;
    localparam int LONG_HOLD   = 300;

    // op code the block leaves unused
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic              fired;
        logic [CH_W-1:0]   fired_channel;
        logic              status;
        logic [TICK_W-1:0] now;
        logic              last;
    } timer_result_t;

    // shadow of the channel bank plus the results still owed by the block
    class timer_shadow;
        logic [TICK_W-1:0] tick_now;
        logic [TICK_W-1:0] due_at [CHANNELS];
        logic [TICK_W-1:0] reload [CHANNELS];
        logic              periodic [CHANNELS];
        logic              running [CHANNELS];
        timer_result_t     pending_results [$];
        int                mismatches;

        function new();
            tick_now   = '0;
            mismatches = 0;
            foreach (due_at[i])
            begin
                due_at[i]   = '0;
                reload[i]   = '0;
                periodic[i] = 1'b0;
                running[i]  = 1'b0;
            end
        endfunction

        function void owe(logic f, logic [CH_W-1:0] c, status_t s, logic l);
            timer_result_t r;
            r.fired         = f;
            r.fired_channel = c;
            r.status        = s;
            r.now           = tick_now;
            r.last          = l;
            pending_results.push_back(r);
        endfunction

        function void apply_item(logic [OP_W-1:0] op_v, logic [CH_W-1:0] ch_v,
                                 logic [TICK_W-1:0] per_v, logic rep_v);
            logic [TICK_W-1:0] lag;
            int                hits [$];
            case (op_v)
                OP_TICK:
                begin
                    tick_now = tick_now + 1'b1;
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        // wrap-safe: due when the signed distance is not negative
                        lag = tick_now - due_at[i];
                        if (running[i] && !lag[TICK_W-1])
                        begin
                            if (periodic[i])
                                due_at[i] = tick_now + reload[i];
                            else
                                running[i] = 1'b0;
                            hits.push_back(i);
                        end
                    end
                    if (hits.size() == 0)
                        owe(1'b0, '0, ST_OK, 1'b1);
                    foreach (hits[k])
                        owe(1'b1, CH_W'(hits[k]), ST_OK, k == hits.size() - 1);
                end
                OP_START:
                begin
                    if (per_v == '0 || int'(ch_v) >= CHANNELS)
                        owe(1'b0, '0, ST_BAD_ARG, 1'b1);
                    else
                    begin
                        reload[ch_v]   = per_v;
                        periodic[ch_v] = rep_v;
                        due_at[ch_v]   = tick_now + per_v;
                        running[ch_v]  = 1'b1;
                        owe(1'b0, '0, ST_OK, 1'b1);
                    end
                end
                OP_STOP:
                begin
                    if (int'(ch_v) >= CHANNELS)
                        owe(1'b0, '0, ST_BAD_ARG, 1'b1);
                    else
                    begin
                        running[ch_v] = 1'b0;
                        owe(1'b0, '0, ST_OK, 1'b1);
                    end
                end
                default:
                    owe(1'b0, '0, ST_OK, 1'b1);
            endcase
        endfunction

        function void check_result(logic f, logic [CH_W-1:0] c, logic s,
                                   logic [TICK_W-1:0] t, logic l);
            timer_result_t e;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: fired %0d channel %0d now %0d", f, c, t);
                mismatches++;
                return;
            end
            e = pending_results.pop_front();
            if (f !== e.fired)
            begin
                $error("fired: expected %0d, actual %0d", e.fired, f);
                mismatches++;
            end
            if (c !== e.fired_channel)
            begin
                $error("fired_channel: expected %0d, actual %0d", e.fired_channel, c);
                mismatches++;
            end
            if (s !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, s);
                mismatches++;
            end
            if (t !== e.now)
            begin
                $error("now: expected %0d, actual %0d", e.now, t);
                mismatches++;
            end
            if (l !== e.last)
            begin
                $error("last: expected %0d, actual %0d", e.last, l);
                mismatches++;
            end
        endfunction
    endclass

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic [OP_W-1:0]   op         = '0;
    logic [CH_W-1:0]   channel    = '0;
    logic [TICK_W-1:0] period     = '0;
    logic              repeat_req = 1'b0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic              fired;
    logic [CH_W-1:0]   fired_channel;
    logic              status;
    logic [TICK_W-1:0] now;
    logic              last;

    timer_shadow shadow;
    bit          in_idle     = 1'b1;
    bit          out_idle    = 1'b1;
    int          hold_cycles = 0;
    int          quiet_cycles = 0;

    software_timer_bank #(.CHANNELS(CHANNELS)) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .channel       (channel),
        .period        (period),
        .repeat_req    (repeat_req),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .fired         (fired),
        .fired_channel (fired_channel),
        .status        (status),
        .now           (now),
        .last          (last)
    );

    always #6 clk = ~clk;

    task automatic send_item(input logic [OP_W-1:0] op_v, input logic [CH_W-1:0] ch_v,
                             input logic [TICK_W-1:0] per_v, input logic rep_v);
        int gap;
        gap = in_idle ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= op_v;
        channel    <= ch_v;
        period     <= per_v;
        repeat_req <= rep_v;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        shadow.apply_item(op_v, ch_v, per_v, rep_v);
    endtask

    task automatic send_random_item();
        int                pick;
        int                span;
        logic [TICK_W-1:0] per_v;
        logic [CH_W-1:0]   ch_v;
        pick = $urandom_range(0, 99);
        span = $urandom_range(0, 99);
        ch_v = CH_W'($urandom_range(0, 7));
        if (span < 6)
            per_v = '0;
        else if (span < 90)
            per_v = $urandom_range(1, 12);
        else
            per_v = $urandom;
        if (pick < 45)
            send_item(OP_TICK, ch_v, per_v, 1'($urandom_range(0, 1)));
        else if (pick < 80)
            send_item(OP_START, ch_v, per_v, 1'($urandom_range(0, 1)));
        else if (pick < 93)
            send_item(OP_STOP, ch_v, per_v, 1'($urandom_range(0, 1)));
        else
            send_item(OP_UNUSED, ch_v, per_v, 1'($urandom_range(0, 1)));
    endtask

    // sender stays quiet until every owed result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (shadow.pending_results.size() != 0)
            @(posedge clk);
    endtask

    // result side: random stall per item, or one long hold when requested
    initial
    begin
        int hold;
        forever
        begin
            if (hold_cycles > 0)
            begin
                hold        = hold_cycles;
                hold_cycles = 0;
            end
            else
                hold = out_idle ? $urandom_range(0, 13) : 0;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
            shadow.check_result(fired, fired_channel, status, now, last);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        shadow = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_TICK, 3'd0, '0, 1'b0);
        send_item(OP_STOP, 3'd0, '0, 1'b0);
        send_item(OP_START, 3'd7, '0, 1'b1);
        send_item(OP_UNUSED, 3'd7, '1, 1'b1);
        send_item(OP_START, 3'd0, 32'd1, 1'b0);
        send_item(OP_START, 3'd7, 32'd2, 1'b1);
        // half the counter range ahead reads as still in the future
        send_item(OP_START, 3'd3, 32'h8000_0000, 1'b0);
        // due time lands one tick behind, so it fires on every tick
        send_item(OP_START, 3'd5, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_TICK, 3'd0, '0, 1'b0);
        send_item(OP_TICK, 3'd7, '1, 1'b1);
        send_item(OP_STOP, 3'd5, '0, 1'b0);
        // every channel due on the same tick
        for (int i = 0; i < CHANNELS; i++)
            send_item(OP_START, CH_W'(i), 32'd1, 1'b1);
        send_item(OP_TICK, 3'd0, '0, 1'b0);
        send_item(OP_STOP, 3'd3, '0, 1'b0);
        send_item(OP_TICK, 3'd0, '0, 1'b0);
        drain_results();

        repeat (30) send_random_item();
        drain_results();

        // long result hold with a gap-free sender so the block backs up
        hold_cycles = LONG_HOLD;
        in_idle     = 1'b0;
        repeat (20) send_random_item();
        drain_results();

        out_idle = 1'b0;
        repeat (15) send_random_item();
        in_idle = 1'b1;
        repeat (13) send_random_item();
        in_idle  = 1'b0;
        out_idle = 1'b1;
        repeat (10) send_random_item();
        drain_results();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (shadow.mismatches == 0 && shadow.pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
